// ----- src/agc_pkg.sv -----
// ============================================================================
// agc_pkg
// Shared types, constants and tables of the asymmetric 2-D Gaussian cost block.
// ============================================================================
`default_nettype none

package agc_pkg;

  // CORDIC
  localparam int unsigned ANGLE_ITERATIONS_DFLT = 16;
  localparam int unsigned ATAN_ENTRIES          = 32;
  localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008218;
  localparam logic signed [32:0] PI_Q29          = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Q29     = 33'sd843314857;

  // quadratic terms
  localparam int unsigned QUOT_BITS = 29;
  localparam logic [QUOT_BITS-1:0] QMAX_Q24 = QUOT_BITS'(1) << 28;

  // exponential
  localparam int unsigned HORNER_STEPS  = 6;
  localparam int unsigned EXP_SQUARINGS = 8;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_FRONT = 2'd0;
  localparam logic [1:0] REG_REAR  = 2'd1;
  localparam logic [1:0] REG_SIDE  = 2'd2;
  localparam logic [31:0] VAR_RESET = 32'd65536;

  typedef struct packed {
    logic [31:0] front_variance;
    logic [31:0] rear_variance;
    logic [31:0] side_variance;
  } agc_cfg_t;

  // atan(2^-i) in Q2.29
  function automatic logic signed [32:0] atan_q29(input logic [4:0] idx);
    case (idx)
      5'd0:  return 33'sd421657428;
      5'd1:  return 33'sd248918915;
      5'd2:  return 33'sd131521918;
      5'd3:  return 33'sd66762579;
      5'd4:  return 33'sd33510843;
      5'd5:  return 33'sd16771758;
      5'd6:  return 33'sd8387925;
      5'd7:  return 33'sd4194219;
      5'd8:  return 33'sd2097141;
      5'd9:  return 33'sd1048575;
      5'd10: return 33'sd524288;
      5'd11: return 33'sd262144;
      5'd12: return 33'sd131072;
      5'd13: return 33'sd65536;
      5'd14: return 33'sd32768;
      5'd15: return 33'sd16384;
      5'd16: return 33'sd8192;
      5'd17: return 33'sd4096;
      5'd18: return 33'sd2048;
      5'd19: return 33'sd1024;
      5'd20: return 33'sd512;
      5'd21: return 33'sd256;
      5'd22: return 33'sd128;
      5'd23: return 33'sd64;
      5'd24: return 33'sd32;
      5'd25: return 33'sd16;
      5'd26: return 33'sd8;
      5'd27: return 33'sd4;
      5'd28: return 33'sd2;
      5'd29: return 33'sd1;
      default: return 33'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/agc_cfg.sv -----
// ============================================================================
// agc_cfg
// Variance registers behind a small APB slave.
// ============================================================================
`default_nettype none

module agc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [agc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready,
  output agc_pkg::agc_cfg_t                  cfg_o
);
  import agc_pkg::*;

  agc_cfg_t   regs_r;
  logic [1:0] idx;
  logic       wr_en;

  assign idx        = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.front_variance <= VAR_RESET;
      regs_r.rear_variance  <= VAR_RESET;
      regs_r.side_variance  <= VAR_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FRONT: regs_r.front_variance <= cfg_pwdata;
        REG_REAR:  regs_r.rear_variance  <= cfg_pwdata;
        REG_SIDE:  regs_r.side_variance  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRONT: cfg_prdata = regs_r.front_variance;
      REG_REAR:  cfg_prdata = regs_r.rear_variance;
      REG_SIDE:  cfg_prdata = regs_r.side_variance;
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg_o = regs_r;

endmodule

`default_nettype wire

// ----- src/agc_cordic.sv -----
// ============================================================================
// agc_cordic
// Pipelined rotation CORDIC: heading in, cos/sin in Q1.28 out, one step a stage.
// ============================================================================
`default_nettype none

module agc_cordic #(
  parameter int unsigned ITERATIONS = agc_pkg::ANGLE_ITERATIONS_DFLT,
  parameter int unsigned SIDE_W     = 66
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic signed [15:0]       in_heading,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [31:0]       out_cos,
  output logic signed [31:0]       out_sin,
  output logic [SIDE_W-1:0]        out_side
);
  import agc_pkg::*;

  // fold stage
  logic signed [32:0] z_raw, z_fold;
  logic               f_fold;
  logic signed [32:0] z0_r;
  logic               f0_r, v0_r;
  logic [SIDE_W-1:0]  s0_r;

  assign z_raw = {in_heading[15], in_heading, 16'b0};

  always_comb begin
    z_fold = z_raw;
    f_fold = 1'b0;
    if (z_raw > HALF_PI_Q29) begin
      z_fold = z_raw - PI_Q29;
      f_fold = 1'b1;
    end else if (z_raw < -HALF_PI_Q29) begin
      z_fold = z_raw + PI_Q29;
      f_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      z0_r <= z_fold;
      f0_r <= f_fold;
      s0_r <= in_side;
    end
    if (!rst_n) v0_r <= 1'b0;
    else if (ce) v0_r <= in_valid;
  end

  // rotation stages
  logic signed [31:0] x_r [ITERATIONS];
  logic signed [31:0] y_r [ITERATIONS];
  logic signed [32:0] z_r [ITERATIONS];
  logic               f_r [ITERATIONS];
  logic               v_r [ITERATIONS];
  logic [SIDE_W-1:0]  sd_r [ITERATIONS];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
    logic signed [31:0] xi, yi, x_nxt, y_nxt;
    logic signed [32:0] zi, z_nxt;
    logic               fi, vi;
    logic [SIDE_W-1:0]  si;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN_Q28;
      assign yi = '0;
      assign zi = z0_r;
      assign fi = f0_r;
      assign vi = v0_r;
      assign si = s0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
      assign vi = v_r[i-1];
      assign si = sd_r[i-1];
    end

    always_comb begin
      if (zi >= 0) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - atan_q29(5'(i));
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + atan_q29(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
        f_r[i]  <= fi;
        sd_r[i] <= si;
      end
      if (!rst_n) v_r[i] <= 1'b0;
      else if (ce) v_r[i] <= vi;
    end
  end

  // undo the fold by pi
  logic signed [31:0] c_r, s_r;
  logic               vo_r;
  logic [SIDE_W-1:0]  so_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      c_r  <= f_r[ITERATIONS-1] ? -x_r[ITERATIONS-1] : x_r[ITERATIONS-1];
      s_r  <= f_r[ITERATIONS-1] ? -y_r[ITERATIONS-1] : y_r[ITERATIONS-1];
      so_r <= sd_r[ITERATIONS-1];
    end
    if (!rst_n) vo_r <= 1'b0;
    else if (ce) vo_r <= v_r[ITERATIONS-1];
  end

  assign out_valid = vo_r;
  assign out_cos   = c_r;
  assign out_sin   = s_r;
  assign out_side  = so_r;

endmodule

`default_nettype wire

// ----- src/agc_div.sv -----
// ============================================================================
// agc_div
// Two-lane pipelined restoring divider, one quotient bit a stage, clamped to 16.0.
// ============================================================================
`default_nettype none

module agc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [61:0]                     in_num [2],
  input  logic [32:0]                     in_den [2],
  input  logic                            in_sat [2],
  output logic                            out_valid,
  output logic [agc_pkg::QUOT_BITS-1:0]   out_term [2]
);
  import agc_pkg::*;

  logic [61:0] rem0_r [2];
  logic [32:0] den0_r [2];
  logic        sat0_r [2];
  logic        v0_r;

  logic [61:0]          rem_r [QUOT_BITS][2];
  logic [32:0]          den_r [QUOT_BITS][2];
  logic                 sat_r [QUOT_BITS][2];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS][2];
  logic                 v_r   [QUOT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (ce) v0_r <= in_valid;
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else if (ce) v_r[j] <= (j == 0) ? v0_r : v_r[(j == 0) ? 0 : j-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // quotient would not fit in QUOT_BITS: saturate up front
    always_ff @(posedge clk) begin
      if (ce) begin
        rem0_r[l] <= in_num[l];
        den0_r[l] <= in_den[l];
        sat0_r[l] <= in_sat[l] | (in_num[l] >= (62'(in_den[l]) << QUOT_BITS));
      end
    end

    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_bit
      localparam int unsigned SH = QUOT_BITS - 1 - j;
      logic [61:0]          ri, dsh, rem_nxt;
      logic [32:0]          di;
      logic                 si, ge;
      logic [QUOT_BITS-1:0] qi;

      if (j == 0) begin : g_first
        assign ri = rem0_r[l];
        assign di = den0_r[l];
        assign si = sat0_r[l];
        assign qi = '0;
      end else begin : g_next
        assign ri = rem_r[j-1][l];
        assign di = den_r[j-1][l];
        assign si = sat_r[j-1][l];
        assign qi = q_r[j-1][l];
      end

      assign dsh     = 62'(di) << SH;
      assign ge      = ri >= dsh;
      assign rem_nxt = ge ? ri - dsh : ri;

      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[j][l] <= rem_nxt;
          den_r[j][l] <= di;
          sat_r[j][l] <= si;
          q_r[j][l]   <= {qi[QUOT_BITS-2:0], ge};
        end
      end
    end

    assign out_term[l] = (sat_r[QUOT_BITS-1][l] || q_r[QUOT_BITS-1][l] > QMAX_Q24)
                         ? QMAX_Q24 : q_r[QUOT_BITS-1][l];
  end

  assign out_valid = v_r[QUOT_BITS-1];

endmodule

`default_nettype wire

// ----- src/agc_exp.sv -----
// ============================================================================
// agc_exp
// Pipelined exp(-Q): Horner series of exp(-Q/256), then eight squarings.
// ============================================================================
`default_nettype none

module agc_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [29:0] in_q,
  output logic        out_valid,
  output logic [15:0] out_cost
);
  import agc_pkg::*;

  localparam logic [32:0] ONE = 33'h1_0000_0000;

  logic [27:0] q_in;
  logic        z_in;

  // Q >= 16.0 gives zero
  assign z_in = in_q[29] | in_q[28];
  assign q_in = in_q[27:0];

  // per Horner step: A = multiply, B = reciprocal multiply, C = correct and subtract
  logic [27:0] qa_r [HORNER_STEPS], pa_r [HORNER_STEPS];
  logic        za_r [HORNER_STEPS], va_r [HORNER_STEPS];
  logic [27:0] qb_r [HORNER_STEPS], pb_r [HORNER_STEPS], eb_r [HORNER_STEPS];
  logic        zb_r [HORNER_STEPS], vb_r [HORNER_STEPS];
  logic [27:0] qc_r [HORNER_STEPS];
  logic [32:0] hc_r [HORNER_STEPS];
  logic        zc_r [HORNER_STEPS], vc_r [HORNER_STEPS];

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
    localparam int unsigned K = HORNER_STEPS - g;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

    logic [27:0] qi;
    logic [32:0] hi;
    logic        zi, vi;
    logic [60:0] prod_a;
    logic [60:0] prod_b;
    logic [30:0] rem;
    logic [27:0] quot_nxt;

    if (g == 0) begin : g_first
      assign qi = q_in;
      assign hi = ONE;
      assign zi = z_in;
      assign vi = in_valid;
    end else begin : g_next
      assign qi = qc_r[g-1];
      assign hi = hc_r[g-1];
      assign zi = zc_r[g-1];
      assign vi = vc_r[g-1];
    end

    assign prod_a   = 61'(qi) * 61'(hi);
    assign prod_b   = 61'(pa_r[g]) * 61'(RECIP);
    // estimate is low by at most one
    assign rem      = 31'(pb_r[g]) - 31'(eb_r[g]) * 31'(K);
    assign quot_nxt = eb_r[g] + 28'(rem >= 31'(K));

    always_ff @(posedge clk) begin
      if (ce) begin
        qa_r[g] <= qi;
        pa_r[g] <= prod_a[59:32];
        za_r[g] <= zi;
        qb_r[g] <= qa_r[g];
        pb_r[g] <= pa_r[g];
        eb_r[g] <= prod_b[59:32];
        zb_r[g] <= za_r[g];
        qc_r[g] <= qb_r[g];
        hc_r[g] <= ONE - 33'(quot_nxt);
        zc_r[g] <= zb_r[g];
      end
      if (!rst_n) begin
        va_r[g] <= 1'b0;
        vb_r[g] <= 1'b0;
        vc_r[g] <= 1'b0;
      end else if (ce) begin
        va_r[g] <= vi;
        vb_r[g] <= va_r[g];
        vc_r[g] <= vb_r[g];
      end
    end
  end

  // squarings
  logic [31:0] ys_r [EXP_SQUARINGS];
  logic        zs_r [EXP_SQUARINGS], vs_r [EXP_SQUARINGS];

  for (genvar s = 0; s < EXP_SQUARINGS; s++) begin : g_sq
    logic [32:0] yi;
    logic [31:0] yc;
    logic        zi, vi;
    logic [63:0] sq;

    if (s == 0) begin : g_first
      assign yi = hc_r[HORNER_STEPS-1];
      assign zi = zc_r[HORNER_STEPS-1];
      assign vi = vc_r[HORNER_STEPS-1];
    end else begin : g_next
      assign yi = {1'b0, ys_r[s-1]};
      assign zi = zs_r[s-1];
      assign vi = vs_r[s-1];
    end

    assign yc = yi[32] ? 32'hFFFF_FFFF : yi[31:0];
    assign sq = 64'(yc) * 64'(yc);

    always_ff @(posedge clk) begin
      if (ce) begin
        ys_r[s] <= sq[63:32];
        zs_r[s] <= zi;
      end
      if (!rst_n) vs_r[s] <= 1'b0;
      else if (ce) vs_r[s] <= vi;
    end
  end

  // round to Q0.16 and saturate
  logic [32:0] rnd;
  logic [15:0] cost_nxt, cost_r;
  logic        vo_r;

  assign rnd = {1'b0, ys_r[EXP_SQUARINGS-1]} + 33'd32768;

  always_comb begin
    if (zs_r[EXP_SQUARINGS-1])      cost_nxt = '0;
    else if (rnd[32])               cost_nxt = 16'hFFFF;
    else                            cost_nxt = rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (ce) cost_r <= cost_nxt;
    if (!rst_n) vo_r <= 1'b0;
    else if (ce) vo_r <= vs_r[EXP_SQUARINGS-1];
  end

  assign out_valid = vo_r;
  assign out_cost  = cost_r;

endmodule

`default_nettype wire

// ----- src/asymmetric_gaussian_2d_cost_top.sv -----
// ============================================================================
// asymmetric_gaussian_2d_cost_top
// Asymmetric 2-D Gaussian cost of a point around a heading-oriented centre.
// ============================================================================
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  in_      | in  | in_tvalid/in_tready  | point_x, point_y, centre_x,
//           |     |                      | centre_y, heading (144 bits)
//  out_     | out | out_tvalid/out_tready| cost_value (16 bits)
//  cfg_     | in  | APB psel/penable     | front/rear/side variance @ 0x0/4/8
//
//  One beat per cycle sustained while out_tready stays high; the path runs
//  through the CORDIC stages, the 30-stage dividers and the Horner/squaring
//  stages of the exponential.
//  Reset clears all valid flags and loads every variance with 1.0.
//  The pipeline freezes only when the output register holds an untaken beat
//  and the last stage holds a valid one; bubbles keep closing meanwhile.
// ============================================================================
`default_nettype none

module asymmetric_gaussian_2d_cost_top #(
  parameter int unsigned ANGLE_ITERATIONS = agc_pkg::ANGLE_ITERATIONS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // point_x[31:0], point_y[63:32], centre_x[95:64], centre_y[127:96],
  // heading[143:128]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [143:0]                   in_tdata,
  // cost_value[15:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [agc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import agc_pkg::*;

  agc_cfg_t cfg;

  agc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg_o      (cfg)
  );

  // --------------------------------------------------------------------------
  // flow control
  logic ce, out_free, exp_valid;
  logic [15:0] exp_cost;

  assign out_free  = ~out_tvalid | out_tready;
  assign ce        = out_free | ~exp_valid;
  assign in_tready = ce;

  // --------------------------------------------------------------------------
  // offsets
  logic signed [32:0] dx_r, dy_r;
  logic signed [15:0] hd_r;
  logic               v0_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r <= {in_tdata[31], in_tdata[31:0]}   - {in_tdata[95], in_tdata[95:64]};
      dy_r <= {in_tdata[63], in_tdata[63:32]}  - {in_tdata[127], in_tdata[127:96]};
      hd_r <= in_tdata[143:128];
    end
    if (!rst_n) v0_r <= 1'b0;
    else if (ce) v0_r <= in_tvalid;
  end

  logic               cd_valid;
  logic signed [31:0] cd_cos, cd_sin;
  logic [65:0]        cd_side;

  agc_cordic #(
    .ITERATIONS(ANGLE_ITERATIONS),
    .SIDE_W    (66)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v0_r),
    .in_heading(hd_r),
    .in_side   ({dx_r, dy_r}),
    .out_valid (cd_valid),
    .out_cos   (cd_cos),
    .out_sin   (cd_sin),
    .out_side  (cd_side)
  );

  // --------------------------------------------------------------------------
  // rotate the offset into heading frame
  logic signed [32:0] cdx, cdy;
  logic signed [63:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic               v1_r;

  assign cdx = cd_side[65:33];
  assign cdy = cd_side[32:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      pxc_r <= 64'(cdx) * 64'(cd_cos);
      pys_r <= 64'(cdy) * 64'(cd_sin);
      pyc_r <= 64'(cdy) * 64'(cd_cos);
      pxs_r <= 64'(cdx) * 64'(cd_sin);
    end
    if (!rst_n) v1_r <= 1'b0;
    else if (ce) v1_r <= cd_valid;
  end

  logic signed [63:0] u_nxt, u_r, w_r;
  logic [31:0]        var_sel, side_var;
  logic [32:0]        den_u_r, den_w_r;
  logic               v2_r;

  assign u_nxt = pxc_r + pys_r;

  // ahead of the lateral axis uses the front variance; zero reads as one LSB
  always_comb begin
    var_sel  = (u_nxt > 0) ? cfg.front_variance : cfg.rear_variance;
    if (var_sel == '0) var_sel = 32'd1;
    side_var = (cfg.side_variance == '0) ? 32'd1 : cfg.side_variance;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      u_r     <= u_nxt;
      w_r     <= pyc_r - pxs_r;
      den_u_r <= {var_sel, 1'b0};
      den_w_r <= {side_var, 1'b0};
    end
    if (!rst_n) v2_r <= 1'b0;
    else if (ce) v2_r <= v1_r;
  end

  // --------------------------------------------------------------------------
  // magnitudes rounded to Q11.16
  logic [63:0] mag_u, mag_w, rnd_u, rnd_w;
  logic [26:0] mu_r, mw_r;
  logic        su_r, sw_r, v3_r;
  logic [32:0] den_u3_r, den_w3_r;

  assign mag_u = u_r[63] ? 64'(-u_r) : 64'(u_r);
  assign mag_w = w_r[63] ? 64'(-w_r) : 64'(w_r);
  assign rnd_u = mag_u + 64'd134217728;
  assign rnd_w = mag_w + 64'd134217728;

  always_ff @(posedge clk) begin
    if (ce) begin
      mu_r     <= rnd_u[54:28];
      mw_r     <= rnd_w[54:28];
      su_r     <= |rnd_u[63:55];
      sw_r     <= |rnd_w[63:55];
      den_u3_r <= den_u_r;
      den_w3_r <= den_w_r;
    end
    if (!rst_n) v3_r <= 1'b0;
    else if (ce) v3_r <= v2_r;
  end

  logic [61:0] num_r [2];
  logic [32:0] den_r [2];
  logic        sat_r [2];
  logic        v4_r;
  logic [53:0] sq_u, sq_w;

  assign sq_u = 54'(mu_r) * 54'(mu_r);
  assign sq_w = 54'(mw_r) * 54'(mw_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      num_r[0] <= {sq_u, 8'b0};
      num_r[1] <= {sq_w, 8'b0};
      den_r[0] <= den_u3_r;
      den_r[1] <= den_w3_r;
      sat_r[0] <= su_r;
      sat_r[1] <= sw_r;
    end
    if (!rst_n) v4_r <= 1'b0;
    else if (ce) v4_r <= v3_r;
  end

  logic                 dv_valid;
  logic [QUOT_BITS-1:0] dv_term [2];

  agc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (v4_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .in_sat   (sat_r),
    .out_valid(dv_valid),
    .out_term (dv_term)
  );

  logic [29:0] qsum_r;
  logic        v5_r;

  always_ff @(posedge clk) begin
    if (ce) qsum_r <= 30'(dv_term[0]) + 30'(dv_term[1]);
    if (!rst_n) v5_r <= 1'b0;
    else if (ce) v5_r <= dv_valid;
  end

  agc_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (v5_r),
    .in_q     (qsum_r),
    .out_valid(exp_valid),
    .out_cost (exp_cost)
  );

  // --------------------------------------------------------------------------
  // output register
  logic        out_valid_r;
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (out_free) out_data_r <= exp_cost;
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_free) out_valid_r <= exp_valid;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_valid && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline tail is blocked");

  a_out_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exp_valid))
    else $error("output beat without a pipeline result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire
